[src/owm_pkg.sv]
`timescale 1ns / 1ps
// owm_pkg: shared types and constants for the 1-Wire bus master.
// No dependencies; used by every module under src.

package owm_pkg;

    localparam int unsigned TicksW = 10;
    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned DefResetRecoveryTicks = 410;

    // command / operation codes
    localparam logic [2:0] CmdNone  = 3'd0;
    localparam logic [2:0] CmdReset = 3'd1;
    localparam logic [2:0] CmdWBit  = 3'd2;
    localparam logic [2:0] CmdRBit  = 3'd3;
    localparam logic [2:0] CmdWByte = 3'd4;
    localparam logic [2:0] CmdRByte = 3'd5;

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] RegShortLow     = 3'd0;
    localparam logic [CfgIdxW-1:0] RegW1Release    = 3'd1;
    localparam logic [CfgIdxW-1:0] RegW0Low        = 3'd2;
    localparam logic [CfgIdxW-1:0] RegW0Release    = 3'd3;
    localparam logic [CfgIdxW-1:0] RegReadSample   = 3'd4;
    localparam logic [CfgIdxW-1:0] RegReadRecovery = 3'd5;
    localparam logic [CfgIdxW-1:0] RegResetLow     = 3'd6;
    localparam logic [CfgIdxW-1:0] RegPresence     = 3'd7;

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] data;
        logic       bus_level;
    } t_owm_in;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_value;
    } t_owm_out;

    // slot timing, already clamped so that no field is zero
    typedef struct packed {
        logic [TicksW-1:0] short_low;
        logic [TicksW-1:0] w1_release;
        logic [TicksW-1:0] w0_low;
        logic [TicksW-1:0] w0_release;
        logic [TicksW-1:0] read_sample;
        logic [TicksW-1:0] read_recovery;
        logic [TicksW-1:0] reset_low;
        logic [TicksW-1:0] presence;
    } t_owm_timing;

endpackage

[src/owm_cfg_regs.sv]
`timescale 1ns / 1ps
// owm_cfg_regs: slot timing register file with write port.
// Depends on owm_pkg.

module owm_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_wr_en,
    input  logic [owm_pkg::CfgIdxW-1:0]   i_wr_index,
    input  logic [owm_pkg::TicksW-1:0]    i_wr_data,
    output owm_pkg::t_owm_timing          o_timing
);

    owm_pkg::t_owm_timing r_timing;
    logic [owm_pkg::TicksW-1:0] w_val;

    // zero acts as one tick; clamp on the way in
    assign w_val = (i_wr_data == '0) ? owm_pkg::TicksW'(1) : i_wr_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timing.short_low     <= owm_pkg::TicksW'(6);
            r_timing.w1_release    <= owm_pkg::TicksW'(64);
            r_timing.w0_low        <= owm_pkg::TicksW'(60);
            r_timing.w0_release    <= owm_pkg::TicksW'(10);
            r_timing.read_sample   <= owm_pkg::TicksW'(9);
            r_timing.read_recovery <= owm_pkg::TicksW'(55);
            r_timing.reset_low     <= owm_pkg::TicksW'(480);
            r_timing.presence      <= owm_pkg::TicksW'(70);
        end else if (i_wr_en) begin
            unique case (i_wr_index)
                owm_pkg::RegShortLow:     r_timing.short_low     <= w_val;
                owm_pkg::RegW1Release:    r_timing.w1_release    <= w_val;
                owm_pkg::RegW0Low:        r_timing.w0_low        <= w_val;
                owm_pkg::RegW0Release:    r_timing.w0_release    <= w_val;
                owm_pkg::RegReadSample:   r_timing.read_sample   <= w_val;
                owm_pkg::RegReadRecovery: r_timing.read_recovery <= w_val;
                owm_pkg::RegResetLow:     r_timing.reset_low     <= w_val;
                owm_pkg::RegPresence:     r_timing.presence      <= w_val;
                default: ;
            endcase
        end
    end

    assign o_timing = r_timing;

endmodule

[src/owm_core.sv]
`timescale 1ns / 1ps
// owm_core: slot sequencer state and its one-tick update.
// Depends on owm_pkg; timing comes from owm_cfg_regs.

module owm_core #(
    parameter int unsigned RESET_RECOVERY_TICKS = owm_pkg::DefResetRecoveryTicks
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_advance,
    input  owm_pkg::t_owm_in      i_item,
    input  owm_pkg::t_owm_timing  i_timing,
    output owm_pkg::t_owm_out     o_result
);

    localparam logic [1:0] PhIdle    = 2'd0;
    localparam logic [1:0] PhLow     = 2'd1;
    localparam logic [1:0] PhRelease = 2'd2;
    localparam logic [1:0] PhRecover = 2'd3;

    localparam logic [owm_pkg::TicksW-1:0] RecTicks =
        (RESET_RECOVERY_TICKS == 0) ? owm_pkg::TicksW'(1)
                                    : owm_pkg::TicksW'(RESET_RECOVERY_TICKS);

    logic [1:0]                 r_phase, n_phase;
    logic [2:0]                 r_op, n_op;
    logic [owm_pkg::TicksW-1:0] r_tc, n_tc;
    logic [3:0]                 r_bit, n_bit;
    logic [7:0]                 r_shift, n_shift;
    logic [7:0]                 r_result, n_result;
    logic                       n_done;

    // state after the tick step, before the end-of-command check
    logic [1:0]                 s_phase;
    logic [owm_pkg::TicksW-1:0] s_tc;
    logic [owm_pkg::TicksW-1:0] w_len_cur, w_len_new;

    function automatic logic is_wr(input logic [2:0] op);
        return (op == owm_pkg::CmdWBit) || (op == owm_pkg::CmdWByte);
    endfunction

    function automatic logic [owm_pkg::TicksW-1:0] phase_len(
        input logic [1:0]           ph,
        input logic [2:0]           op,
        input logic                 one,
        input owm_pkg::t_owm_timing t
    );
        logic [owm_pkg::TicksW-1:0] len;
        len = t.read_recovery;
        if (ph == PhLow) begin
            if (op == owm_pkg::CmdReset)  len = t.reset_low;
            else if (is_wr(op) && !one)   len = t.w0_low;
            else                          len = t.short_low;
        end else if (ph == PhRelease) begin
            if (op == owm_pkg::CmdReset)  len = t.presence;
            else if (is_wr(op))           len = one ? t.w1_release : t.w0_release;
            else                          len = t.read_sample;
        end else if (op == owm_pkg::CmdReset) begin
            len = RecTicks;
        end
        return len;
    endfunction

    assign w_len_cur = phase_len(r_phase, r_op, r_shift[0], i_timing);

    // tick step
    always_comb begin
        s_phase  = r_phase;
        s_tc     = r_tc;
        n_op     = r_op;
        n_bit    = r_bit;
        n_shift  = r_shift;
        n_result = r_result;
        if (r_phase == PhIdle) begin
            if (i_item.cmd >= owm_pkg::CmdReset && i_item.cmd <= owm_pkg::CmdRByte) begin
                n_op    = i_item.cmd;
                n_bit   = 4'd0;
                n_shift = i_item.data;
                if (i_item.cmd == owm_pkg::CmdRByte) n_result = 8'd0;
                s_phase = PhLow;
                s_tc    = owm_pkg::TicksW'(1);
            end
        end else if (r_tc < w_len_cur) begin
            s_tc = r_tc + owm_pkg::TicksW'(1);
        end else if (r_phase == PhLow) begin
            s_phase = PhRelease;
            s_tc    = owm_pkg::TicksW'(1);
        end else if (r_phase == PhRelease && !is_wr(r_op)) begin
            // read sample point
            if (r_op == owm_pkg::CmdRByte)
                n_result = r_result | (8'(i_item.bus_level) << r_bit[2:0]);
            else
                n_result = {7'd0, i_item.bus_level};
            s_phase = PhRecover;
            s_tc    = owm_pkg::TicksW'(1);
        end else begin
            // end of a write release or a read recovery: next bit
            n_bit   = r_bit + 4'd1;
            n_shift = {1'b0, r_shift[7:1]};
            s_phase = PhLow;
            s_tc    = owm_pkg::TicksW'(1);
        end
    end

    assign w_len_new = phase_len(s_phase, n_op, n_shift[0], i_timing);

    // end-of-command check on the stepped state
    always_comb begin
        n_phase = s_phase;
        n_tc    = s_tc;
        n_done  = 1'b0;
        if (s_phase != PhIdle
            && s_phase == (is_wr(n_op) ? PhRelease : PhRecover)
            && s_tc >= w_len_new
            && !((n_op == owm_pkg::CmdWByte || n_op == owm_pkg::CmdRByte)
                 && n_bit < 4'd7)) begin
            n_done  = 1'b1;
            n_phase = PhIdle;
            n_tc    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PhIdle;
            r_op     <= owm_pkg::CmdNone;
            r_tc     <= '0;
            r_bit    <= '0;
            r_shift  <= '0;
            r_result <= '0;
        end else if (i_advance) begin
            r_phase  <= n_phase;
            r_op     <= n_op;
            r_tc     <= n_tc;
            r_bit    <= n_bit;
            r_shift  <= n_shift;
            r_result <= n_result;
        end
    end

    assign o_result.drive_low  = (n_phase == PhLow);
    assign o_result.busy_res   = (n_phase != PhIdle);
    assign o_result.done_res   = n_done;
    assign o_result.read_value = n_result;

endmodule

[src/onewire_bus_master_unit.sv]
`timescale 1ns / 1ps
// onewire_bus_master_unit: top level of the 1-Wire bus master.
// Depends on owm_pkg, owm_cfg_regs and owm_core.

// Standard-speed 1-Wire master stepped by microsecond ticks. Every input
// transfer is one tick: it carries the sampled bus level and, while the
// master is idle, a command (reset, write/read bit, write/read byte, bytes
// LSB first). Every tick gives exactly one result transfer with the bus
// drive, busy, done and the read value. An item sits in an input register,
// owm_core computes the sequencer update from it combinationally, and the
// result register takes that update when the item moves on, which happens
// when the result register is empty or its transfer completes. One tick is
// taken every cycle while the output side keeps up; the combinational state
// update in owm_core sets that rate. Slot timing lives in eight 10-bit
// registers written over the configuration port (always ready); a value of
// zero acts as one tick. Write them only while the master is idle and
// drained.

module onewire_bus_master_unit #(
    parameter int unsigned RESET_RECOVERY_TICKS = owm_pkg::DefResetRecoveryTicks
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // tick input
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  owm_pkg::t_owm_in             i_in,
    // result output
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output owm_pkg::t_owm_out            o_out,
    // configuration writes
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [owm_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  logic [owm_pkg::TicksW-1:0]   i_cfg_data
);

    owm_pkg::t_owm_timing w_timing;
    owm_pkg::t_owm_out    w_result;

    logic                 r_in_valid;
    owm_pkg::t_owm_in     r_in;
    logic                 r_out_valid;
    owm_pkg::t_owm_out    r_out;

    logic w_accept;
    logic w_advance;
    logic w_out_take;

    // config is never back-pressured
    assign o_cfg_ready = 1'b1;

    owm_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_timing   (w_timing)
    );

    // Input register moves into the sequencer when the result register is
    // empty or its transfer completes this cycle.
    assign w_out_take = r_out_valid && !i_out_stall;
    assign w_advance  = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_advance;
    assign w_accept   = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in <= i_in;
        end
    end

    owm_core #(
        .RESET_RECOVERY_TICKS (RESET_RECOVERY_TICKS)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_item    (r_in),
        .i_timing  (w_timing),
        .o_result  (w_result)
    );

    // result register: holds while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (w_out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

[tb/onewire_bus_master_unit_test.sv]
`timescale 1ns / 1ps
// onewire_bus_master_unit_test: self-checking bench for the 1-Wire bus master.
// Depends on owm_pkg and onewire_bus_master_unit, which also needs owm_cfg_regs and owm_core.

module onewire_bus_master_unit_test;

    // command codes the master must treat as no command
    localparam logic [2:0] CmdSpare6 = 3'd6;
    localparam logic [2:0] CmdSpare7 = 3'd7;

    // level modes for stimulus: fixed low, fixed high or random per tick
    localparam int LvlLow  = 0;
    localparam int LvlHigh = 1;
    localparam int LvlRand = 2;

    // timing register loads
    localparam int TimZero  = 0;
    localparam int TimOne   = 1;
    localparam int TimMax   = 2;
    localparam int TimSmall = 3;

    localparam int QuietLimit = 4000;
    localparam int LongHold   = 300;
    localparam int PadTicks   = 8;
    localparam int RandTicks  = 40;

    typedef enum logic [1:0] {SlotIdle, SlotLow, SlotRelease, SlotRecover} t_slot_phase;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    owm_pkg::t_owm_in i_in = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    owm_pkg::t_owm_out o_out;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [owm_pkg::CfgIdxW-1:0] i_cfg_index = '0;
    logic [owm_pkg::TicksW-1:0] i_cfg_data = '0;

    onewire_bus_master_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------------
    // Predictor: own copy of the sequencer state and of the slot timing
    // ---------------------------------------------------------------------
    logic [owm_pkg::TicksW-1:0] slot_cfg [8];
    t_slot_phase                m_phase;
    logic [2:0]                 m_op;
    logic [owm_pkg::TicksW-1:0] m_ticks;
    logic [3:0]                 m_bit;
    logic [7:0]                 m_shift;
    logic [7:0]                 m_rbyte;

    function automatic logic [owm_pkg::TicksW-1:0] at_least_one(
        input logic [owm_pkg::TicksW-1:0] v
    );
        return (v == '0) ? owm_pkg::TicksW'(1) : v;
    endfunction

    function automatic logic op_is_write();
        return m_op == owm_pkg::CmdWBit || m_op == owm_pkg::CmdWByte;
    endfunction

    // length of the current slot phase, picked by operation and data bit
    function automatic logic [owm_pkg::TicksW-1:0] slot_len();
        logic one;
        one = m_shift[0];
        case (m_phase)
            SlotLow: begin
                if (m_op == owm_pkg::CmdReset)
                    return at_least_one(slot_cfg[owm_pkg::RegResetLow]);
                if (op_is_write() && !one)
                    return at_least_one(slot_cfg[owm_pkg::RegW0Low]);
                return at_least_one(slot_cfg[owm_pkg::RegShortLow]);
            end
            SlotRelease: begin
                if (m_op == owm_pkg::CmdReset)
                    return at_least_one(slot_cfg[owm_pkg::RegPresence]);
                if (op_is_write())
                    return at_least_one(one ? slot_cfg[owm_pkg::RegW1Release]
                                            : slot_cfg[owm_pkg::RegW0Release]);
                return at_least_one(slot_cfg[owm_pkg::RegReadSample]);
            end
            default: begin
                if (m_op == owm_pkg::CmdReset)
                    return at_least_one(
                        owm_pkg::TicksW'(owm_pkg::DefResetRecoveryTicks));
                return at_least_one(slot_cfg[owm_pkg::RegReadRecovery]);
            end
        endcase
    endfunction

    task automatic start_next_bit();
        m_bit   = m_bit + 4'd1;
        m_shift = m_shift >> 1;
        m_phase = SlotLow;
        m_ticks = owm_pkg::TicksW'(1);
    endtask

    // one tick of the master: state update and the bus result it gives
    task automatic advance_master(input owm_pkg::t_owm_in tk,
                                  output owm_pkg::t_owm_out res);
        logic        done;
        t_slot_phase last_ph;
        logic        byte_op;
        done = 1'b0;
        if (m_phase == SlotIdle) begin
            if (tk.cmd >= owm_pkg::CmdReset && tk.cmd <= owm_pkg::CmdRByte) begin
                m_op    = tk.cmd;
                m_bit   = '0;
                m_shift = tk.data;
                if (tk.cmd == owm_pkg::CmdRByte) m_rbyte = '0;
                m_phase = SlotLow;
                m_ticks = owm_pkg::TicksW'(1);
            end
        end else if (m_ticks < slot_len()) begin
            m_ticks = m_ticks + owm_pkg::TicksW'(1);
        end else if (m_phase == SlotLow) begin
            m_phase = SlotRelease;
            m_ticks = owm_pkg::TicksW'(1);
        end else if (m_phase == SlotRelease) begin
            if (op_is_write()) begin
                start_next_bit();
            end else begin
                // first recovery tick samples the bus
                if (m_op == owm_pkg::CmdRByte)
                    m_rbyte[m_bit[2:0]] = m_rbyte[m_bit[2:0]] | tk.bus_level;
                else
                    m_rbyte = {7'd0, tk.bus_level};
                m_phase = SlotRecover;
                m_ticks = owm_pkg::TicksW'(1);
            end
        end else begin
            start_next_bit();
        end

        if (m_phase != SlotIdle) begin
            last_ph = op_is_write() ? SlotRelease : SlotRecover;
            byte_op = m_op == owm_pkg::CmdWByte || m_op == owm_pkg::CmdRByte;
            if (m_phase == last_ph && m_ticks >= slot_len() && !(byte_op && m_bit < 4'd7)) begin
                done    = 1'b1;
                m_phase = SlotIdle;
                m_ticks = '0;
            end
        end

        res.drive_low  = m_phase == SlotLow;
        res.busy_res   = m_phase != SlotIdle;
        res.done_res   = done;
        res.read_value = m_rbyte;
    endtask

    // ---------------------------------------------------------------------
    // Tick driver, bus result monitor and receiver stall
    // ---------------------------------------------------------------------
    owm_pkg::t_owm_in  pending_ticks[$];
    owm_pkg::t_owm_out pending_bus_results[$];
    int       send_idle_pct = 0;
    int       recv_stall_pct = 0;
    int       errors = 0;
    int       quiet_cycles = 0;
    logic     in_taken = 1'b0;
    logic     out_taken = 1'b0;
    logic     hold_req = 1'b0;
    logic     hold_ack = 1'b0;
    int       hold_left = 0;
    owm_pkg::t_owm_out want;
    owm_pkg::t_owm_out fresh;

    // a new tick is offered only once the previous one has been transferred
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                i_in       <= pending_ticks.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver: random stalls, or one long hold-off when asked for
    always @(negedge i_clk) begin
        if (hold_req != hold_ack) begin
            hold_ack    <= hold_req;
            hold_left   <= LongHold;
            i_out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= $urandom_range(99) < recv_stall_pct;
        end
    end

    always @(posedge i_clk) begin
        in_taken  = i_rst_n && i_in_valid && !o_in_stall;
        out_taken = i_rst_n && o_out_valid && !i_out_stall;
        if (out_taken) begin
            if (pending_bus_results.size() == 0) begin
                $display("%0t: result transfer with none expected, got %0h", $time, o_out);
                errors++;
            end else begin
                want = pending_bus_results.pop_front();
                if (o_out !== want) begin
                    $display("%0t: result mismatch, expected %0h got %0h",
                             $time, want, o_out);
                    errors++;
                end
            end
        end
        if (in_taken) begin
            advance_master(i_in, fresh);
            pending_bus_results.push_back(fresh);
        end
        if (in_taken || out_taken || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else if (i_rst_n) begin
            quiet_cycles++;
            if (quiet_cycles >= QuietLimit) begin
                $display("onewire_bus_master_unit_test: FAIL");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------------
    function automatic logic pick_level(input int mode);
        return (mode == LvlRand) ? logic'($urandom_range(1)) : logic'(mode);
    endfunction

    task automatic queue_tick(input logic [2:0] cmd, input logic [7:0] data, input int lvl);
        owm_pkg::t_owm_in tk;
        tk.cmd       = cmd;
        tk.data      = data;
        tk.bus_level = pick_level(lvl);
        pending_ticks.push_back(tk);
    endtask

    // every queued tick transferred and every bus result back
    task automatic wait_drained();
        do @(posedge i_clk);
        while (pending_ticks.size() != 0 || i_in_valid || pending_bus_results.size() != 0);
    endtask

    // feed no-command ticks until the master has gone idle again
    task automatic settle(input int lvl);
        logic [2:0] cmd;
        wait_drained();
        while (m_phase != SlotIdle) begin
            repeat (PadTicks) begin
                case ($urandom_range(2))
                    0: cmd = owm_pkg::CmdNone;
                    1: cmd = CmdSpare6;
                    default: cmd = CmdSpare7;
                endcase
                queue_tick(cmd, 8'($urandom_range(255)), lvl);
            end
            wait_drained();
        end
    endtask

    task automatic run_cmd(input logic [2:0] cmd, input logic [7:0] data, input int lvl);
        queue_tick(cmd, data, lvl);
        settle(lvl);
    endtask

    task automatic write_reg(input logic [owm_pkg::CfgIdxW-1:0] idx,
                             input logic [owm_pkg::TicksW-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        slot_cfg[idx] = val;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic load_timing(input int mode);
        logic [owm_pkg::TicksW-1:0] val;
        for (int r = int'(owm_pkg::RegShortLow); r <= int'(owm_pkg::RegPresence); r++) begin
            case (mode)
                TimZero: val = '0;
                TimOne:  val = owm_pkg::TicksW'(1);
                TimMax:  val = '1;
                default: val = owm_pkg::TicksW'($urandom_range(1, 8));
            endcase
            write_reg(owm_pkg::CfgIdxW'(r), val);
        end
    endtask

    // some bit and byte commands, a few spare codes, mostly plain ticks;
    // commands that land while busy are simply dropped by the master
    task automatic random_ticks(input int n);
        int         pick;
        logic [2:0] cmd;
        repeat (n) begin
            pick = $urandom_range(99);
            if (pick < 35)
                cmd = 3'($urandom_range(owm_pkg::CmdWBit, owm_pkg::CmdRByte));
            else if (pick < 45)
                cmd = $urandom_range(1) ? CmdSpare6 : CmdSpare7;
            else
                cmd = owm_pkg::CmdNone;
            queue_tick(cmd, 8'($urandom_range(255)), LvlRand);
        end
    endtask

    initial begin
        slot_cfg[owm_pkg::RegShortLow]     = 10'd6;
        slot_cfg[owm_pkg::RegW1Release]    = 10'd64;
        slot_cfg[owm_pkg::RegW0Low]        = 10'd60;
        slot_cfg[owm_pkg::RegW0Release]    = 10'd10;
        slot_cfg[owm_pkg::RegReadSample]   = 10'd9;
        slot_cfg[owm_pkg::RegReadRecovery] = 10'd55;
        slot_cfg[owm_pkg::RegResetLow]     = 10'd480;
        slot_cfg[owm_pkg::RegPresence]     = 10'd70;
        m_phase = SlotIdle;
        m_op    = owm_pkg::CmdNone;
        m_ticks = '0;
        m_bit   = '0;
        m_shift = '0;
        m_rbyte = '0;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset timing left as is: one read slot at the default lengths
        run_cmd(owm_pkg::CmdRBit, 8'h00, LvlHigh);

        // one-tick timing: presence seen, both write bit values, reads of
        // both levels, bytes, spare codes, commands dropped while busy
        load_timing(TimOne);
        run_cmd(owm_pkg::CmdReset, 8'h00, LvlLow);
        run_cmd(owm_pkg::CmdWBit, 8'hFE, LvlRand);
        run_cmd(owm_pkg::CmdWBit, 8'h01, LvlRand);
        run_cmd(owm_pkg::CmdRBit, 8'hFF, LvlLow);
        run_cmd(owm_pkg::CmdWByte, 8'hA5, LvlRand);
        run_cmd(owm_pkg::CmdRByte, 8'h00, LvlRand);
        run_cmd(owm_pkg::CmdRByte, 8'h00, LvlHigh);
        run_cmd(CmdSpare6, 8'hFF, LvlRand);
        run_cmd(CmdSpare7, 8'h00, LvlRand);
        queue_tick(owm_pkg::CmdWBit, 8'h00, LvlRand);
        queue_tick(owm_pkg::CmdRByte, 8'hFF, LvlRand);
        queue_tick(owm_pkg::CmdWByte, 8'h3C, LvlRand);
        settle(LvlRand);

        // shortest timing, sender idling
        send_idle_pct = 65;
        random_ticks(RandTicks);
        settle(LvlRand);

        // zero timing acts as one tick, receiver stalling
        send_idle_pct  = 0;
        recv_stall_pct = 65;
        load_timing(TimZero);
        random_ticks(RandTicks);
        settle(LvlRand);

        // small mixed timing, both sides idling, one long hold-off so the
        // master's input backs up while ticks keep being offered
        send_idle_pct  = 38;
        recv_stall_pct = 38;
        load_timing(TimSmall);
        random_ticks(RandTicks);
        @(posedge i_clk);
        hold_req = !hold_req;
        settle(LvlRand);

        // small mixed timing, no idling at all
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        load_timing(TimSmall);
        random_ticks(RandTicks);
        settle(LvlRand);

        repeat (10) @(posedge i_clk);
        if (errors == 0) begin
            $display("onewire_bus_master_unit_test: PASS");
        end else begin
            $display("onewire_bus_master_unit_test: FAIL");
        end
        $finish;
    end

endmodule
